### rtl/sssp_pkg.sv
// sssp_pkg: shared types and codes of the shortest-path core
// command and result word structs, register indexes, sequencer states
// no dependencies
package sssp_pkg;

	localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
	localparam logic [1:0] REG_EDGE_COUNT   = 2'd1;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_RUN  = 1'b1;

	localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic               command;
		logic [7:0]         edge_index;
		logic [5:0]         edge_from;
		logic [5:0]         edge_to;
		logic signed [15:0] edge_weight;
		logic [5:0]         source_vertex;
	} cmd_t;

	typedef struct packed {
		logic [5:0]         vertex_id;
		logic signed [31:0] distance;
		logic               reachable;
		logic               negative_cycle;
		logic               last;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE_RD,
		ST_DIST_RD,
		ST_ADD,
		ST_CMP,
		ST_OUT_RD,
		ST_OUT_EMIT
	} state_t;

endpackage

### rtl/single_source_shortest_paths_core.sv
// single_source_shortest_paths_core: bellman-ford over a stored edge list
// edge memory, distance memory with reachability flops, sequencer
// depends on sssp_pkg
//
// A word with command load writes one edge into the edge memory and is taken
// whenever busy is low, so loads may follow back to back. A word with command
// run starts a search from source_vertex: busy stays high until the last
// result is out. Each edge takes a four-step edge read, distance read, add,
// and compare with write back sequence over the edge and distance memories;
// the relaxation passes are followed by a negative cycle check pass, and
// each result is streamed by a read and an emit step. Results come with a
// one-cycle strobe and cannot be held off. A detected negative cycle gives
// one result with negative_cycle and last set. Write vertex_count and
// edge_count only while busy is low and no result is pending.
module single_source_shortest_paths_core
	import sssp_pkg::*;
#(
	parameter int MAX_VERTICES = 64,
	parameter int MAX_EDGES    = 256,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  cmd_t       cmd,
	input  logic       wr_en,
	input  logic [1:0] wr_index,
	input  logic [8:0] wr_data,
	output logic       strobe,
	output result_t    result
);

	localparam int VW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int JW  = $clog2(MAX_EDGES + 1);
	localparam int EDW = 12 + WEIGHT_BITS;

	// configuration registers
	logic [6:0] vcount_q;
	logic [8:0] ecount_q;

	// memories: edge list and distances
	logic [EDW-1:0] edge_mem [MAX_EDGES];
	logic [31:0]    dist_mem [MAX_VERTICES];
	logic [EDW-1:0] edge_rd;
	logic [31:0]    dist_rd_a, dist_rd_b;
	// reachability kept in flops, cleared at once at run start
	logic [MAX_VERTICES-1:0] reach_q;

	state_t state_q, state_d;

	// run context
	logic [6:0]    nv_q;
	logic [JW-1:0] ne_q;
	logic [6:0]    pass_q;
	logic [JW-1:0] j_q;
	logic [6:0]    k_q;
	logic          check_q;

	// per-edge pipeline registers
	logic [5:0]                    from_s1, to_s1;
	logic signed [WEIGHT_BITS-1:0] w_s1;
	logic                          inr_s1;
	logic signed [31:0]            cand_s2, dto_s2;
	logic                          rf_s2, rt_s2, inr_s2;

	// combinational controls
	logic [VW-1:0] rd_addr_a, rd_addr_b;
	logic          dist_we;
	logic [VW-1:0] dist_waddr;
	logic [31:0]   dist_wdata;
	logic          run_go, load_go, relax, edge_wrap, pass_wrap;
	logic [6:0]    nv_eff;
	logic [JW-1:0] ne_eff;
	logic          src_ok;
	logic [31:0]   wext;
	logic signed [32:0] sum;
	logic signed [31:0] sum_sat;

	assign busy    = (state_q != ST_IDLE);
	assign load_go = start && !busy && (cmd.command == CMD_LOAD);
	assign run_go  = start && !busy && (cmd.command == CMD_RUN);

	// clamp the register values for this run
	always_comb begin
		if (vcount_q == 7'd0)
			nv_eff = 7'd1;
		else if (int'(vcount_q) > MAX_VERTICES)
			nv_eff = 7'(MAX_VERTICES);
		else
			nv_eff = vcount_q;
		if (int'(ecount_q) > MAX_EDGES)
			ne_eff = JW'(MAX_EDGES);
		else
			ne_eff = JW'(ecount_q);
	end
	assign src_ok = ({1'b0, cmd.source_vertex} < nv_eff);

	// weight kept as its low bits, sign-extended above the field
	assign wext = 32'(cmd.edge_weight);

	// saturating add of from-distance and weight
	assign sum = 33'(signed'(dist_rd_a)) + 33'(w_s1);
	always_comb begin
		if (sum[32] != sum[31])
			sum_sat = sum[32] ? INT_MIN : INT_MAX;
		else
			sum_sat = sum[31:0];
	end

	assign relax     = inr_s2 && rf_s2 && (!rt_s2 || (cand_s2 < dto_s2));
	assign edge_wrap = (j_q + 1'b1 == ne_q);
	assign pass_wrap = (pass_q + 7'd1 == nv_q);

	// next state and memory controls
	always_comb begin
		state_d    = state_q;
		rd_addr_a  = from_s1[VW-1:0];
		rd_addr_b  = to_s1[VW-1:0];
		dist_we    = 1'b0;
		dist_waddr = to_s1[VW-1:0];
		dist_wdata = cand_s2;
		case (state_q)
			ST_IDLE: begin
				if (run_go) begin
					dist_we    = src_ok;
					dist_waddr = cmd.source_vertex[VW-1:0];
					dist_wdata = 32'd0;
					// a single vertex still gets the negative cycle sweep
					if (ne_eff == '0)
						state_d = ST_OUT_RD;
					else
						state_d = ST_EDGE_RD;
				end
			end
			ST_EDGE_RD: state_d = ST_DIST_RD;
			ST_DIST_RD: begin
				rd_addr_a = edge_rd[EDW-1 -: 6][VW-1:0];
				rd_addr_b = edge_rd[EDW-7 -: 6][VW-1:0];
				state_d   = ST_ADD;
			end
			ST_ADD: state_d = ST_CMP;
			ST_CMP: begin
				if (check_q) begin
					if (relax)
						state_d = ST_IDLE;
					else if (edge_wrap)
						state_d = ST_OUT_RD;
					else
						state_d = ST_EDGE_RD;
				end else begin
					dist_we = relax;
					state_d = ST_EDGE_RD;
				end
			end
			ST_OUT_RD: begin
				rd_addr_a = k_q[VW-1:0];
				state_d   = ST_OUT_EMIT;
			end
			ST_OUT_EMIT: begin
				if (k_q + 7'd1 == nv_q)
					state_d = ST_IDLE;
				else
					state_d = ST_OUT_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// memories
	always_ff @(posedge clk) begin
		if (load_go && int'(cmd.edge_index) < MAX_EDGES)
			edge_mem[EW'(cmd.edge_index)] <=
				{cmd.edge_from, cmd.edge_to, wext[WEIGHT_BITS-1:0]};
		edge_rd <= edge_mem[j_q[EW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (dist_we)
			dist_mem[dist_waddr] <= dist_wdata;
		dist_rd_a <= dist_mem[rd_addr_a];
		dist_rd_b <= dist_mem[rd_addr_b];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 7'd1;
			ecount_q <= 9'd0;
			reach_q  <= '0;
			nv_q     <= 7'd1;
			ne_q     <= '0;
			pass_q   <= 7'd1;
			j_q      <= '0;
			k_q      <= 7'd0;
			check_q  <= 1'b0;
			strobe   <= 1'b0;
		end else begin
			strobe <= 1'b0;
			if (wr_en) begin
				case (wr_index)
					REG_VERTEX_COUNT: vcount_q <= wr_data[6:0];
					REG_EDGE_COUNT:   ecount_q <= wr_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (run_go) begin
						reach_q <= '0;
						if (src_ok)
							reach_q[cmd.source_vertex[VW-1:0]] <= 1'b1;
						nv_q    <= nv_eff;
						ne_q    <= ne_eff;
						pass_q  <= 7'd1;
						j_q     <= '0;
						k_q     <= 7'd0;
						// no relaxation pass with one vertex, only the check
						check_q <= (nv_eff == 7'd1);
					end
				end
				ST_CMP: begin
					if (check_q && relax) begin
						strobe <= 1'b1;
					end else begin
						if (!check_q && relax)
							reach_q[to_s1[VW-1:0]] <= 1'b1;
						if (edge_wrap) begin
							j_q <= '0;
							if (pass_wrap)
								check_q <= 1'b1;
							else
								pass_q <= pass_q + 7'd1;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				ST_OUT_EMIT: begin
					strobe <= 1'b1;
					k_q    <= k_q + 7'd1;
				end
				default: ;
			endcase
		end
	end

	// per-edge datapath and result word
	always_ff @(posedge clk) begin
		case (state_q)
			ST_DIST_RD: begin
				from_s1 <= edge_rd[EDW-1 -: 6];
				to_s1   <= edge_rd[EDW-7 -: 6];
				w_s1    <= edge_rd[WEIGHT_BITS-1:0];
				inr_s1  <= ({1'b0, edge_rd[EDW-1 -: 6]} < nv_q) &&
				           ({1'b0, edge_rd[EDW-7 -: 6]} < nv_q);
			end
			ST_ADD: begin
				cand_s2 <= sum_sat;
				dto_s2  <= dist_rd_b;
				rf_s2   <= reach_q[from_s1[VW-1:0]];
				rt_s2   <= reach_q[to_s1[VW-1:0]];
				inr_s2  <= inr_s1;
			end
			ST_CMP: begin
				result.vertex_id      <= 6'd0;
				result.distance       <= 32'sd0;
				result.reachable      <= 1'b0;
				result.negative_cycle <= 1'b1;
				result.last           <= 1'b1;
			end
			ST_OUT_EMIT: begin
				result.vertex_id      <= 6'(k_q);
				result.distance       <= reach_q[k_q[VW-1:0]] ? dist_rd_a : 32'sd0;
				result.reachable      <= reach_q[k_q[VW-1:0]];
				result.negative_cycle <= 1'b0;
				result.last           <= (k_q + 7'd1 == nv_q);
			end
			default: ;
		endcase
	end

	// a result word only follows a compare or an output step
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ($past(state_q) == ST_CMP || $past(state_q) == ST_OUT_EMIT))
		else $error("result strobe without a producing step");

	a_cycle_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.negative_cycle) |-> result.last)
		else $error("negative cycle word not marked last");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |-> !busy)
		else $error("busy after last result word");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		run_go |=> busy)
		else $error("run accepted but core not busy");

endmodule
